// ===== rtl/core/fcpt_pkg.sv =====
// ----------------------------------------------------------------------------
// fcpt_pkg: shared types, constants and functions
// Holds the command/status structs, mode codes, saturation helpers and the
// quarter-wave sine table used by the regulator tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcpt_pkg;

  localparam int SpeedPeriodDef = 16;
  localparam int PolePairs      = 7;
  localparam int CurrentLimit   = 18918;
  localparam int PosOutLimit    = 100;
  localparam int AlignAlpha     = 18000;
  localparam int SineEntries    = 512;
  localparam int SineLog2       = $clog2(SineEntries);
  localparam int QuarterEntries = SineEntries / 4;
  localparam int CfgIdxW        = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegMode       = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTarget     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPosKp      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPosKi      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpdKp      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSpdKi      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegElecOffset = 3'd6;
  localparam logic [CfgIdxW-1:0] RegZeroRef    = 3'd7;

  typedef enum logic [2:0] {
    MODE_TORQUE     = 3'd0,
    MODE_SPEED      = 3'd1,
    MODE_POS_SINGLE = 3'd2,
    MODE_POS_MULTI  = 3'd3,
    MODE_ALIGN      = 3'd4
  } mode_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_UNWRAP,
    OP_SPEED,
    OP_LEAD_MUL,
    OP_LEAD_WB,
    OP_TQ_MUL,
    OP_TQ_WB,
    OP_PE,
    OP_PKI_MUL,
    OP_PKI_WB,
    OP_PKP_MUL,
    OP_PKP_WB,
    OP_SPE,
    OP_SKI_MUL,
    OP_SKI_WB,
    OP_SKP_MUL,
    OP_SKP_WB,
    OP_ANGLE,
    OP_SIN_MUL,
    OP_SIN_WB,
    OP_COS_MUL,
    OP_COS_WB
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic        period_hit;
    logic [2:0]  mode;
  } status_t;

  // result item, first field in the highest bits
  typedef struct packed {
    logic [15:0] speed_estimate;
    logic [15:0] iq_command;
    logic [15:0] v_beta;
    logic [15:0] v_alpha;
  } result_t;

  function automatic logic signed [31:0] sat32(logic signed [50:0] x);
    logic signed [31:0] r;
    if (x > 51'sd2147483647) r = 32'sh7FFFFFFF;
    else if (x < -51'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [50:0] x);
    logic signed [15:0] r;
    if (x > 51'sd32767) r = 16'sh7FFF;
    else if (x < -51'sd32768) r = 16'sh8000;
    else r = x[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_sym(logic signed [50:0] x,
                                                   logic signed [31:0] lim);
    logic signed [31:0] r;
    if (x > 51'(lim)) r = lim;
    else if (x < -51'(lim)) r = -lim;
    else r = x[31:0];
    return r;
  endfunction

  // series evaluation of one quarter-wave entry, elaboration only
  function automatic logic [15:0] quarter_sine(int k);
    longint unsigned w, a, a2, term;
    longint sum, v;
    w    = longint'(k) * longint'((1 << 30) / QuarterEntries);
    a    = (w * 64'd1686629713) >> 30;
    a2   = (a * a) >> 30;
    term = a;
    sum  = longint'(a);
    term = ((term * a2) >> 30) / 6;   sum = sum - longint'(term);
    term = ((term * a2) >> 30) / 20;  sum = sum + longint'(term);
    term = ((term * a2) >> 30) / 42;  sum = sum - longint'(term);
    term = ((term * a2) >> 30) / 72;  sum = sum + longint'(term);
    term = ((term * a2) >> 30) / 110; sum = sum - longint'(term);
    term = ((term * a2) >> 30) / 156; sum = sum + longint'(term);
    if (sum < 0) sum = 0;
    v = (sum * 32767 + (64'sd1 << 29)) >>> 30;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  typedef logic [15:0] qsine_t [0:QuarterEntries];

  function automatic qsine_t build_qsine();
    qsine_t t;
    for (int k = 0; k <= QuarterEntries; k++) begin
      t[k] = quarter_sine(k);
    end
    return t;
  endfunction

  localparam qsine_t QSine = build_qsine();

  // full-wave sine by quadrant folding of the quarter table
  function automatic logic signed [16:0] sine_at(logic [SineLog2-1:0] idx);
    logic [SineLog2-2:0] k;
    logic signed [16:0]  v;
    k = {1'b0, idx[SineLog2-3:0]};
    if (idx[SineLog2-2]) k = (SineLog2-1)'(QuarterEntries) - k;
    v = signed'({1'b0, QSine[k]});
    return idx[SineLog2-1] ? -v : v;
  endfunction

endpackage

// ===== rtl/core/fcpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcpt_ctrl: tick sequencer
// Steps the datapath through unwrap, speed update, regulator and vector
// output, one operation per cycle unless the output register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcpt_ctrl import fcpt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    out_free_i,
  output logic    out_load_o,
  input  status_t stat_i,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_UNWRAP, S_SPEED, S_LEAD_MUL, S_LEAD_WB, S_TQ_MUL, S_TQ_WB,
    S_PE, S_PKI_MUL, S_PKI_WB, S_PKP_MUL, S_PKP_WB,
    S_SPE, S_SKI_MUL, S_SKI_WB, S_SKP_MUL, S_SKP_WB,
    S_ANGLE, S_SIN_MUL, S_SIN_WB, S_COS_MUL, S_COS_WB, S_OUT
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load_o = (state_q == S_OUT) && out_free_i;

  always_comb begin
    unique case (state_q)
      S_UNWRAP:   cmd_o.op = OP_UNWRAP;
      S_SPEED:    cmd_o.op = OP_SPEED;
      S_LEAD_MUL: cmd_o.op = OP_LEAD_MUL;
      S_LEAD_WB:  cmd_o.op = OP_LEAD_WB;
      S_TQ_MUL:   cmd_o.op = OP_TQ_MUL;
      S_TQ_WB:    cmd_o.op = OP_TQ_WB;
      S_PE:       cmd_o.op = OP_PE;
      S_PKI_MUL:  cmd_o.op = OP_PKI_MUL;
      S_PKI_WB:   cmd_o.op = OP_PKI_WB;
      S_PKP_MUL:  cmd_o.op = OP_PKP_MUL;
      S_PKP_WB:   cmd_o.op = OP_PKP_WB;
      S_SPE:      cmd_o.op = OP_SPE;
      S_SKI_MUL:  cmd_o.op = OP_SKI_MUL;
      S_SKI_WB:   cmd_o.op = OP_SKI_WB;
      S_SKP_MUL:  cmd_o.op = OP_SKP_MUL;
      S_SKP_WB:   cmd_o.op = OP_SKP_WB;
      S_ANGLE:    cmd_o.op = OP_ANGLE;
      S_SIN_MUL:  cmd_o.op = OP_SIN_MUL;
      S_SIN_WB:   cmd_o.op = OP_SIN_WB;
      S_COS_MUL:  cmd_o.op = OP_COS_MUL;
      S_COS_WB:   cmd_o.op = OP_COS_WB;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:     if (in_valid_i) state_q <= S_UNWRAP;
        S_UNWRAP:   state_q <= stat_i.period_hit ? S_SPEED : S_ANGLE;
        S_SPEED:    state_q <= S_LEAD_MUL;
        S_LEAD_MUL: state_q <= S_LEAD_WB;
        S_LEAD_WB: begin
          unique case (stat_i.mode)
            MODE_TORQUE:                    state_q <= S_TQ_MUL;
            MODE_SPEED:                     state_q <= S_SPE;
            MODE_POS_SINGLE, MODE_POS_MULTI: state_q <= S_PE;
            default:                        state_q <= S_ANGLE;
          endcase
        end
        S_TQ_MUL:   state_q <= S_TQ_WB;
        S_TQ_WB:    state_q <= S_ANGLE;
        S_PE:       state_q <= S_PKI_MUL;
        S_PKI_MUL:  state_q <= S_PKI_WB;
        S_PKI_WB:   state_q <= S_PKP_MUL;
        S_PKP_MUL:  state_q <= S_PKP_WB;
        S_PKP_WB:   state_q <= S_SPE;
        S_SPE:      state_q <= S_SKI_MUL;
        S_SKI_MUL:  state_q <= S_SKI_WB;
        S_SKI_WB:   state_q <= S_SKP_MUL;
        S_SKP_MUL:  state_q <= S_SKP_WB;
        S_SKP_WB:   state_q <= S_ANGLE;
        S_ANGLE:    state_q <= S_SIN_MUL;
        S_SIN_MUL:  state_q <= S_SIN_WB;
        S_SIN_WB:   state_q <= S_COS_MUL;
        S_COS_MUL:  state_q <= S_COS_WB;
        S_COS_WB:   state_q <= S_OUT;
        S_OUT:      if (out_free_i) state_q <= S_IDLE;
        default:    state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/fcpt_dp.sv =====
// ----------------------------------------------------------------------------
// fcpt_dp: regulator datapath
// Configuration registers, loop state and one shared 33x17 multiplier with
// a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcpt_dp import fcpt_pkg::*; #(
  parameter int SPEED_PERIOD = SpeedPeriodDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_load_i,
  input  logic [13:0]        in_pos_i,
  input  cmd_t               cmd_i,
  output status_t            stat_o,
  output result_t            res_o
);

  localparam int DivW = $clog2(SPEED_PERIOD);
  localparam logic [31:0] SpdRecip =
    32'(((64'd1 << 32) + 64'(SPEED_PERIOD) - 64'd1) / 64'(SPEED_PERIOD));

  // configuration
  logic [2:0]         mode_q;
  logic signed [31:0] target_q;
  logic signed [15:0] pos_kp_q, pos_ki_q, spd_kp_q, spd_ki_q;
  logic [13:0]        elec_offset_q, zero_ref_q;

  // loop state
  logic [13:0]        pos_q, last_q;
  logic [31:0]        turn_q, pstart_q;
  logic [DivW-1:0]    div_q;
  logic signed [15:0] ms_q, lead_q, drive_q;
  logic signed [31:0] pi_q, po_q, si_q, so_q;

  // working registers
  logic signed [31:0] e_q;
  logic signed [49:0] p_q;
  logic signed [16:0] sin_q, cos_q;
  logic [15:0]        va_q, vb_q;

  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [15:0] step_raw, step_fold;
  logic [15:0]        mag;
  logic signed [31:0] e_sp, e_ps;
  logic [13:0]        ang_sum, ang;
  logic [SineLog2-1:0] sidx;
  logic signed [49:0] q15;
  logic signed [31:0] psat, ssum;
  logic               period_hit;

  assign period_hit = (div_q == DivW'(SPEED_PERIOD - 1));
  assign stat_o.period_hit = period_hit;
  assign stat_o.mode       = mode_q;

  assign res_o.v_alpha        = (mode_q == MODE_ALIGN) ? 16'(AlignAlpha) : va_q;
  assign res_o.v_beta         = (mode_q == MODE_ALIGN) ? 16'd0 : vb_q;
  assign res_o.iq_command     = drive_q;
  assign res_o.speed_estimate = ms_q;

  always_comb begin
    step_raw = signed'({2'b00, pos_q}) - signed'({2'b00, last_q});
    if (step_raw > 16'sd8192) step_fold = step_raw - 16'sd16384;
    else if (step_raw < -16'sd8192) step_fold = step_raw + 16'sd16384;
    else step_fold = step_raw;

    mag = ms_q[15] ? (~ms_q + 16'd1) : ms_q;

    // speed error against the target speed or the position loop output
    e_sp = sat32(51'(ms_q) - ((mode_q == MODE_SPEED) ? 51'(target_q) : 51'(po_q)));

    // position error, folded by a full turn in single-turn mode
    if (mode_q == MODE_POS_MULTI) begin
      e_ps = signed'(target_q - turn_q);
    end else begin
      e_ps = signed'(target_q + 32'(zero_ref_q) - 32'(last_q));
      if (e_ps < -32'sd8192) e_ps = e_ps + 32'sd16384;
      else if (e_ps > 32'sd8192) e_ps = e_ps - 32'sd16384;
    end

    ang_sum = pos_q + lead_q[13:0] + elec_offset_q;
    ang     = 14'(20'(ang_sum) * 20'(PolePairs));
    sidx    = ang[13 -: SineLog2];

    q15 = p_q >>> 15;

    unique case (cmd_i.op)
      OP_LEAD_MUL: begin
        mul_a = signed'({1'b0, SpdRecip});
        mul_b = signed'({1'b0, mag});
      end
      OP_TQ_MUL: begin
        mul_a = 33'(target_q);
        mul_b = 17'(CurrentLimit);
      end
      OP_PKI_MUL: begin mul_a = 33'(e_q); mul_b = 17'(pos_ki_q); end
      OP_PKP_MUL: begin mul_a = 33'(e_q); mul_b = 17'(pos_kp_q); end
      OP_SKI_MUL: begin mul_a = 33'(e_q); mul_b = 17'(spd_ki_q); end
      OP_SKP_MUL: begin mul_a = 33'(e_q); mul_b = 17'(spd_kp_q); end
      OP_SIN_MUL: begin mul_a = 33'(drive_q); mul_b = -sin_q; end
      OP_COS_MUL: begin mul_a = 33'(drive_q); mul_b = cos_q; end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    // proportional term plus integral, both saturated
    if ((cmd_i.op == OP_PKP_WB)) psat = sat32(51'(q15));
    else psat = sat32(51'(p_q));
    ssum = sat32(51'(psat) + ((cmd_i.op == OP_PKP_WB) ? 51'(pi_q) : 51'(si_q)));
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    if (cmd_i.op == OP_SPE) e_q <= e_sp;
    if (cmd_i.op == OP_PE) e_q <= e_ps;
    if (cmd_i.op == OP_ANGLE) begin
      sin_q <= sine_at(sidx);
      cos_q <= sine_at(sidx + SineLog2'(QuarterEntries));
    end
    if (cmd_i.op == OP_SIN_WB) va_q <= q15[15:0];
    if (cmd_i.op == OP_COS_WB) vb_q <= q15[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_TORQUE;
      target_q      <= '0;
      pos_kp_q      <= '0;
      pos_ki_q      <= '0;
      spd_kp_q      <= '0;
      spd_ki_q      <= '0;
      elec_offset_q <= '0;
      zero_ref_q    <= '0;
      pos_q         <= '0;
      last_q        <= '0;
      turn_q        <= '0;
      pstart_q      <= '0;
      div_q         <= '0;
      ms_q          <= '0;
      lead_q        <= '0;
      drive_q       <= '0;
      pi_q          <= '0;
      po_q          <= '0;
      si_q          <= '0;
      so_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegMode:       mode_q        <= cfg_wdata_i[2:0];
          RegTarget:     target_q      <= cfg_wdata_i;
          RegPosKp:      pos_kp_q      <= cfg_wdata_i[15:0];
          RegPosKi:      pos_ki_q      <= cfg_wdata_i[15:0];
          RegSpdKp:      spd_kp_q      <= cfg_wdata_i[15:0];
          RegSpdKi:      spd_ki_q      <= cfg_wdata_i[15:0];
          RegElecOffset: elec_offset_q <= cfg_wdata_i[13:0];
          RegZeroRef:    zero_ref_q    <= cfg_wdata_i[13:0];
          default: ;
        endcase
      end
      if (in_load_i) pos_q <= in_pos_i;

      unique case (cmd_i.op)
        OP_UNWRAP: begin
          last_q <= pos_q;
          turn_q <= turn_q + 32'(step_fold);
          div_q  <= period_hit ? '0 : div_q + DivW'(1);
        end
        OP_SPEED: begin
          ms_q     <= sat16(51'(signed'(turn_q - pstart_q)));
          pstart_q <= turn_q;
        end
        OP_LEAD_WB: lead_q <= ms_q[15] ? -signed'(p_q[47:32]) : signed'(p_q[47:32]);
        OP_TQ_WB:   drive_q <= sat16(51'(q15));
        OP_PKI_WB: begin
          // hold the integral while the output sits on a limit in that direction
          if (!((po_q >= 32'sd100 && e_q > 0) || (po_q <= -32'sd100 && e_q < 0)))
            pi_q <= sat32(51'(pi_q) + 51'(q15));
        end
        OP_PKP_WB:  po_q <= clamp_sym(51'(ssum), 32'(PosOutLimit));
        OP_SKI_WB: begin
          if (!((so_q >= 32'(CurrentLimit) && e_q > 0) ||
                (so_q <= -32'(CurrentLimit) && e_q < 0)))
            si_q <= sat32(51'(si_q) + 51'(sat32(51'(p_q))));
        end
        OP_SKP_WB: begin
          so_q    <= clamp_sym(51'(ssum), 32'(CurrentLimit));
          drive_q <= 16'(clamp_sym(51'(ssum), 32'(CurrentLimit)));
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/foc_cascaded_pi_tick_top.sv =====
// ----------------------------------------------------------------------------
// foc_cascaded_pi_tick_top: cascaded position/speed/torque regulator tick
// On a speed-period tick the speed update and the regulator steps of the
// selected mode run before the vector output; every product passes through the
// single shared multiplier. A new item is accepted only once the previous
// result has been loaded into the output register. Reset clears the
// configuration, the loop state and the output valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module foc_cascaded_pi_tick_top import fcpt_pkg::*; #(
  parameter int SPEED_PERIOD = SpeedPeriodDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,   // [13:0] encoder_position, [15:14] zero
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [63:0]        m_axis_tdata    // v_alpha, v_beta, iq_command, speed_estimate
);

  cmd_t    cmd;
  status_t stat;
  result_t res;
  logic    in_fire, out_load, out_free;
  logic    out_valid_q;
  result_t out_q;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  fcpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fcpt_dp #(
    .SPEED_PERIOD (SPEED_PERIOD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_load_i   (in_fire),
    .in_pos_i    (s_axis_tdata[13:0]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (res)
  );

  // result holding register: hold until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef ASSERT_OFF
  // busy after an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready) else $error("accepted item while busy");

  // never overwrite a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready)) else $error("result overwritten");

  // a loaded result is presented next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid) else $error("loaded result not shown");
`endif

endmodule
